@@ src/tvsq_pkg.sv @@
`timescale 1ns / 1ps

package tvsq_pkg;

    // field widths
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned CMD_W    = 8;
    localparam int unsigned PITCH_W  = 7;
    localparam int unsigned OCTAVE_W = 4;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned DELAY_W  = 3;
    localparam int unsigned PRE_W    = 5;

    // reset values
    localparam logic [TICK_W-1:0]  BEAT_MASK_RESET = 16'd4095;
    localparam logic [DELAY_W-1:0] DELAY_RESET     = 3'd1;

    // octave code: low bits all ones silence the voice
    localparam logic [2:0] OCT_SILENT  = 3'd7;
    // octave low two bits that drop the high bit of the reload value
    localparam logic [1:0] OCT_NO_HIGH = 2'd3;

    // command byte: top bit marks a pitch command
    localparam int unsigned CMD_PITCH_BIT = 7;

    // per-voice write request from the command decoder
    typedef struct packed {
        logic                pitch_we;
        logic                octave_we;
        logic [PITCH_W-1:0]  pitch;
        logic [OCTAVE_W-1:0] octave;
    } voice_wr_t;

    // per-item command status
    typedef struct packed {
        logic taken;
        logic starved;
    } cmd_status_t;

    // tick prescale mask per octave code
    function automatic logic [PRE_W-1:0] prescale_mask(input logic [2:0] code);
        logic [PRE_W-1:0] m;
        unique case (code)
            3'd0:    m = 5'd0;
            3'd1:    m = 5'd1;
            3'd2:    m = 5'd3;
            3'd3:    m = 5'd0;
            3'd4:    m = 5'd7;
            3'd5:    m = 5'd15;
            3'd6:    m = 5'd31;
            default: m = 5'd0;
        endcase
        return m;
    endfunction

endpackage

@@ src/tvsq_voice.sv @@
`timescale 1ns / 1ps

module tvsq_voice (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [4:0]             tick_low,
    input  tvsq_pkg::voice_wr_t    wr,
    output logic                   level_next
);

    logic [tvsq_pkg::OCTAVE_W-1:0] octave_reg, octave_next;
    logic [tvsq_pkg::PITCH_W-1:0]  pitch_reg, pitch_next;
    logic [tvsq_pkg::COUNT_W-1:0]  counter_reg, counter_next;
    logic                          level_reg;

    logic                          run;
    logic [tvsq_pkg::COUNT_W-1:0]  cnt_dec;
    logic [tvsq_pkg::COUNT_W-1:0]  reload;

    // voice counts when it is not silent and its prescale bits of the tick are all zero
    assign run = (octave_reg[2:0] != tvsq_pkg::OCT_SILENT) &&
                 ((tick_low & tvsq_pkg::prescale_mask(octave_reg[2:0])) == 5'd0);
    assign cnt_dec = counter_reg - 8'd1;
    assign reload  = {1'b0, (octave_reg[1:0] != tvsq_pkg::OCT_NO_HIGH), pitch_reg[6:1]};

    // count first, then apply any command write of this item
    always_comb begin
        octave_next  = octave_reg;
        pitch_next   = pitch_reg;
        counter_next = counter_reg;
        level_next   = level_reg;
        if (run) begin
            if (cnt_dec == 8'd0) begin
                counter_next = reload;
                level_next   = ~level_reg;
            end else begin
                counter_next = cnt_dec;
            end
        end
        if (wr.pitch_we) begin
            pitch_next = wr.pitch;
        end
        if (wr.octave_we) begin
            octave_next = wr.octave;
            if (wr.octave[2:0] == tvsq_pkg::OCT_SILENT) begin
                level_next = 1'b0;
            end
        end
    end

    // voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octave_reg  <= '0;
            pitch_reg   <= '0;
            counter_reg <= '0;
            level_reg   <= 1'b0;
        end else if (step_en) begin
            octave_reg  <= octave_next;
            pitch_reg   <= pitch_next;
            counter_reg <= counter_next;
            level_reg   <= level_next;
        end
    end

endmodule

@@ src/tvsq_cmd.sv @@
`timescale 1ns / 1ps

module tvsq_cmd (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [tvsq_pkg::TICK_W-1:0]   tick_count,
    input  logic [tvsq_pkg::TICK_W-1:0]   beat_mask,
    input  logic [tvsq_pkg::CMD_W-1:0]    cmd_byte,
    input  logic                          cmd_valid,
    output tvsq_pkg::voice_wr_t           wr0,
    output tvsq_pkg::voice_wr_t           wr1,
    output tvsq_pkg::cmd_status_t         status
);

    logic [tvsq_pkg::DELAY_W-1:0] note_delay_reg, note_delay_next;
    logic                         parity_reg, parity_next;

    logic [tvsq_pkg::DELAY_W-1:0] delay_mid;
    logic                         due;
    logic                         take;
    logic                         is_pitch;
    logic                         sel;

    // note delay counts down on beat ticks; a command is due at zero
    always_comb begin
        if (note_delay_reg == 3'd0) begin
            due       = 1'b1;
            delay_mid = 3'd0;
        end else if ((tick_count & beat_mask) == 16'd0) begin
            due       = (note_delay_reg == 3'd1);
            delay_mid = note_delay_reg - 3'd1;
        end else begin
            due       = 1'b0;
            delay_mid = note_delay_reg;
        end
    end

    assign take     = due && cmd_valid;
    assign is_pitch = cmd_byte[tvsq_pkg::CMD_PITCH_BIT];
    assign sel      = cmd_byte[6];

    assign status.taken   = take;
    assign status.starved = due && !cmd_valid;

    // decode into voice writes
    always_comb begin
        wr0.pitch     = cmd_byte[6:0];
        wr0.octave    = cmd_byte[5:2];
        wr1.pitch     = cmd_byte[6:0];
        wr1.octave    = cmd_byte[5:2];
        wr0.pitch_we  = take && is_pitch && !parity_reg;
        wr1.pitch_we  = take && is_pitch && parity_reg;
        wr0.octave_we = take && !is_pitch && !sel;
        wr1.octave_we = take && !is_pitch && sel;
    end

    // octave commands load the delay; voice 0 adds its octave top bit
    always_comb begin
        note_delay_next = delay_mid;
        if (take && !is_pitch) begin
            note_delay_next = {(!sel && cmd_byte[5]), cmd_byte[1:0]};
        end
        parity_next = parity_reg ^ take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            note_delay_reg <= tvsq_pkg::DELAY_RESET;
            parity_reg     <= 1'b0;
        end else if (step_en) begin
            note_delay_reg <= note_delay_next;
            parity_reg     <= parity_next;
        end
    end

endmodule

@@ src/two_voice_square_tone_sequencer.sv @@
`timescale 1ns / 1ps

// an item accepted on s_ passes the input register, then the result register, to m_
// throughput: one item per cycle unless m_tready stalls; the tick update sits
// between the input and result registers and state updates in that same cycle
// reset: synchronous active-low aresetn clears voices, tick count and parity,
// sets note delay to 1 and beat_mask to 4095; both pipeline stages empty
module two_voice_square_tone_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cmd_byte
    input  logic        s_tuser,   // [0] cmd_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] audio_bit, [1] cmd_taken, [2] cmd_starved, zeros
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata  // beat_mask
);

    logic [tvsq_pkg::TICK_W-1:0] beat_mask_reg;
    logic [tvsq_pkg::TICK_W-1:0] tick_count_reg;

    logic                        in_valid_reg;
    logic [tvsq_pkg::CMD_W-1:0]  in_byte_reg;
    logic                        in_cmd_valid_reg;

    logic                        out_valid_reg;
    logic [2:0]                  out_data_reg;

    logic                        advance;
    logic                        step_en;
    logic                        level0, level1;
    logic                        audio;
    tvsq_pkg::voice_wr_t         wr0, wr1;
    tvsq_pkg::cmd_status_t       status;

    // handshake: the input stage moves when the result stage can take an item
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_mask_reg <= tvsq_pkg::BEAT_MASK_RESET;
        end else if (cfg_wen) begin
            beat_mask_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg      <= s_tdata;
            in_cmd_valid_reg <= s_tuser;
        end
    end

    // tick counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
        end else if (step_en) begin
            tick_count_reg <= tick_count_reg + 16'd1;
        end
    end

    tvsq_cmd u_cmd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .tick_count (tick_count_reg),
        .beat_mask  (beat_mask_reg),
        .cmd_byte   (in_byte_reg),
        .cmd_valid  (in_cmd_valid_reg),
        .wr0        (wr0),
        .wr1        (wr1),
        .status     (status)
    );

    tvsq_voice u_voice0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .tick_low   (tick_count_reg[4:0]),
        .wr         (wr0),
        .level_next (level0)
    );

    tvsq_voice u_voice1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .tick_low   (tick_count_reg[4:0]),
        .wr         (wr1),
        .level_next (level1)
    );

    // tick parity picks the voice heard
    assign audio = tick_count_reg[0] ? level1 : level0;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= {status.starved, status.taken, audio};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_data_reg};

    // a command is never both taken and starved
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg[1] && out_data_reg[2]))
        else $error("result marks a command both taken and starved");

    // a processed item always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("processed item lost before the result register");

    // the tick count advances by exactly one per processed item
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> (tick_count_reg == $past(tick_count_reg) + 16'd1))
        else $error("tick count did not advance with a processed item");

    // a taken command implies the input flagged it as present
    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && status.taken) |-> in_cmd_valid_reg)
        else $error("command taken without a valid command byte");

endmodule

@@ dv/tone_sequencer_checker.sv @@
`timescale 1ns / 1ps

module tone_sequencer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cmd_byte
    input  logic        s_tuser,   // [0] cmd_valid
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [0] audio_bit, [1] cmd_taken, [2] cmd_starved, zeros
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata, // beat_mask
    output int          mismatch_count,
    output int          ticks_in_flight
);

    typedef struct {
        logic audio_bit;
        logic cmd_taken;
        logic cmd_starved;
    } tick_result_t;

    // tick prescale mask per octave code, the silent code never looks it up
    localparam logic [tvsq_pkg::PRE_W-1:0] TICK_PRESCALE [8] =
        '{5'd0, 5'd1, 5'd3, 5'd0, 5'd7, 5'd15, 5'd31, 5'd0};

    // shadow of the sequencer state
    logic [tvsq_pkg::TICK_W-1:0]   beat_mask_q;
    logic [tvsq_pkg::TICK_W-1:0]   tick_q;
    logic [tvsq_pkg::OCTAVE_W-1:0] octave_q  [2];
    logic [tvsq_pkg::PITCH_W-1:0]  pitch_q   [2];
    logic [tvsq_pkg::COUNT_W-1:0]  counter_q [2];
    logic                          level_q   [2];
    logic [tvsq_pkg::DELAY_W-1:0]  delay_q;
    logic                          parity_q;

    tick_result_t expected_ticks [$];
    int           predicted_n = 0;
    int           received_n  = 0;

    assign ticks_in_flight = predicted_n - received_n;

    // one voice: prescaled down-count, reload and toggle at zero
    task automatic clock_voice(input int v);
        logic [2:0] code;
        code = octave_q[v][2:0];
        if (code != tvsq_pkg::OCT_SILENT &&
            (tick_q[tvsq_pkg::PRE_W-1:0] & TICK_PRESCALE[code]) == '0) begin
            counter_q[v] = counter_q[v] - 1'b1;
            if (counter_q[v] == '0) begin
                counter_q[v] = {1'b0, octave_q[v][1:0] != tvsq_pkg::OCT_NO_HIGH,
                                pitch_q[v][tvsq_pkg::PITCH_W-1:1]};
                level_q[v]   = ~level_q[v];
            end
        end
    endtask

    // decode one command byte popped from the song stream
    task automatic take_command(input logic [tvsq_pkg::CMD_W-1:0] b);
        logic v;
        if (b[tvsq_pkg::CMD_PITCH_BIT]) begin
            pitch_q[parity_q] = b[tvsq_pkg::PITCH_W-1:0];
        end else begin
            v = b[6];
            octave_q[v] = b[5:2];
            if (b[4:2] == tvsq_pkg::OCT_SILENT)
                level_q[v] = 1'b0;
            delay_q = {v == 1'b0 && b[5], b[1:0]};
        end
        parity_q = ~parity_q;
    endtask

    // advance the shadow by one audio tick
    task automatic predict_tick(input logic [tvsq_pkg::CMD_W-1:0] b, input logic cmd_ok,
                                output tick_result_t r);
        logic due;
        clock_voice(0);
        clock_voice(1);
        due = 1'b0;
        if (delay_q == '0) begin
            due = 1'b1;
        end else if ((tick_q & beat_mask_q) == '0) begin
            delay_q = delay_q - 1'b1;
            due     = (delay_q == '0);
        end
        r.cmd_taken   = due && cmd_ok;
        r.cmd_starved = due && !cmd_ok;
        if (r.cmd_taken)
            take_command(b);
        r.audio_bit = level_q[tick_q[0]];
        tick_q = tick_q + 1'b1;
    endtask

    task automatic compare_bit(input string field, input logic want, input logic got,
                               inout int errs);
        if (want !== got) begin
            $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
            errs++;
        end
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin
        tick_result_t want;
        tick_result_t got;
        int           errs;
        errs = 0;
        if (!aresetn) begin
            beat_mask_q = tvsq_pkg::BEAT_MASK_RESET;
            tick_q      = '0;
            delay_q     = tvsq_pkg::DELAY_RESET;
            parity_q    = 1'b0;
            for (int v = 0; v < 2; v++) begin
                octave_q[v]  = '0;
                pitch_q[v]   = '0;
                counter_q[v] = '0;
                level_q[v]   = 1'b0;
            end
            expected_ticks.delete();
            predicted_n    <= 0;
            received_n     <= 0;
            mismatch_count <= 0;
        end else begin
            if (cfg_wen)
                beat_mask_q = cfg_wdata;
            if (s_tvalid && s_tready) begin
                predict_tick(s_tdata, s_tuser, want);
                expected_ticks.push_back(want);
                predicted_n <= predicted_n + 1;
            end
            if (m_tvalid && m_tready) begin
                received_n <= received_n + 1;
                if (expected_ticks.size() == 0) begin
                    $display("%0t: item with none expected, actual %02h", $time, m_tdata);
                    errs++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_bit("audio_bit", want.audio_bit, m_tdata[0], errs);
                    compare_bit("cmd_taken", want.cmd_taken, m_tdata[1], errs);
                    compare_bit("cmd_starved", want.cmd_starved, m_tdata[2], errs);
                end
            end
            mismatch_count <= mismatch_count + errs;
        end
    end

endmodule

@@ dv/two_voice_square_tone_sequencer_tb.sv @@
`timescale 1ns / 1ps

module two_voice_square_tone_sequencer_tb;

    localparam int HOLD_CYCLES = 300;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;   // [7:0] cmd_byte
    logic        s_tuser   = 1'b0; // [0] cmd_valid
    logic        m_tready  = 1'b0;
    logic        cfg_wen   = 1'b0;
    logic [15:0] cfg_wdata = '0;   // beat_mask
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;          // [0] audio_bit, [1] cmd_taken, [2] cmd_starved, zeros

    int mismatch_count;
    int ticks_in_flight;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    bit hold_req       = 1'b0;
    bit hold_done      = 1'b0;
    int hold_left      = 0;

    two_voice_square_tone_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    tone_sequencer_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .ticks_in_flight (ticks_in_flight)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [tvsq_pkg::CMD_W-1:0] pitch_cmd(
            input logic [tvsq_pkg::PITCH_W-1:0] p);
        logic [tvsq_pkg::CMD_W-1:0] b;
        b = '0;
        b[tvsq_pkg::CMD_PITCH_BIT] = 1'b1;
        b[tvsq_pkg::PITCH_W-1:0]   = p;
        return b;
    endfunction

    function automatic logic [tvsq_pkg::CMD_W-1:0] octave_cmd(
            input logic v,
            input logic [tvsq_pkg::OCTAVE_W-1:0] code,
            input logic [1:0] delay);
        return {1'b0, v, code, delay};
    endfunction

    // offer one tick, with random idle cycles ahead of it
    task automatic send_tick(input logic [tvsq_pkg::CMD_W-1:0] b, input logic cmd_ok);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd_ok;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // song-like stream: mostly pitch and octave commands, some raw bytes
    task automatic send_song_tick();
        logic [tvsq_pkg::CMD_W-1:0]    b;
        logic [tvsq_pkg::OCTAVE_W-1:0] code;
        logic [1:0]                    delay;
        int                            roll;
        roll = $urandom_range(99);
        if (roll < 40) begin
            b = pitch_cmd($urandom_range(1) ? 7'($urandom_range(3))
                                            : 7'($urandom_range(127)));
        end else if (roll < 80) begin
            // favor codes without the reload high bit so voices toggle fast
            code  = $urandom_range(1) ? ($urandom_range(1) ? 4'd3 : 4'd11)
                                      : 4'($urandom_range(15));
            delay = $urandom_range(1) ? 2'd0 : 2'($urandom_range(3));
            b = octave_cmd($urandom_range(1), code, delay);
        end else begin
            b = 8'($urandom_range(255));
        end
        send_tick(b, $urandom_range(99) < 85);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ticks_in_flight != 0)
            @(posedge aclk);
    endtask

    task automatic write_beat_mask(input logic [tvsq_pkg::TICK_W-1:0] mask);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic run_phase(input logic [tvsq_pkg::TICK_W-1:0] mask, input int idle,
                             input int stall, input int n);
        settle();
        write_beat_mask(mask);
        send_idle_pct = idle;
        stall_pct    <= stall;
        repeat (n)
            send_song_tick();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk at the reset beat mask
        send_tick(pitch_cmd(7'd127), 1'b1);
        send_tick(pitch_cmd(7'd0), 1'b1);
        send_tick(octave_cmd(1'b0, 4'd0, 2'd0), 1'b1);
        send_tick(8'h00, 1'b0);
        send_tick(8'hff, 1'b0);
        send_tick(octave_cmd(1'b1, {1'b0, tvsq_pkg::OCT_SILENT}, 2'd0), 1'b1);
        send_tick(octave_cmd(1'b1, {1'b1, tvsq_pkg::OCT_SILENT}, 2'd0), 1'b1);
        send_tick(octave_cmd(1'b1, {2'b00, tvsq_pkg::OCT_NO_HIGH}, 2'd0), 1'b1);
        send_tick(pitch_cmd(7'd1), 1'b1);
        send_tick(pitch_cmd(7'd2), 1'b1);
        for (int code = 0; code < 7; code++)
            send_tick(octave_cmd(1'b0, 4'(code), 2'd0), 1'b1);
        send_tick(octave_cmd(1'b0, {2'b00, tvsq_pkg::OCT_NO_HIGH}, 2'd0), 1'b1);
        send_tick(octave_cmd(1'b1, 4'd15, 2'd3), 1'b1);
        repeat (3)
            send_tick(8'($urandom_range(255)), 1'b1);

        // random phases over beat masks and idle patterns
        run_phase(16'd0, 0, 0, 150);
        run_phase(16'd1, 85, 0, 120);
        run_phase(16'd3, 0, 85, 120);
        run_phase(16'hffff, 34, 34, 80);

        // long result hold-off while the sender keeps pushing
        settle();
        write_beat_mask(16'($urandom_range(7)));
        send_idle_pct = 0;
        stall_pct    <= 0;
        hold_req     <= 1'b1;
        repeat (150)
            send_song_tick();

        // closing full-rate run with a small beat mask
        run_phase(16'($urandom_range(15)), 0, 0, 60);

        settle();
        repeat (12) @(posedge aclk);
        if (mismatch_count == 0 && ticks_in_flight == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
